// ----- src/ptt_pkg.sv -----
// shared types and codes for the periodic timer table
package ptt_pkg;

    localparam int unsigned ID_W    = 16;
    localparam int unsigned PER_W   = 32;
    localparam int unsigned EV_W    = 3;
    localparam int unsigned OP_W    = 2;
    localparam int unsigned MAX_OUT = 16;
    localparam int unsigned RCNT_W  = $clog2(MAX_OUT + 1);

    localparam int unsigned S_DATA_W = 56;
    localparam int unsigned M_DATA_W = 24;

    localparam logic [OP_W-1:0] OP_SET  = 2'd0;
    localparam logic [OP_W-1:0] OP_KILL = 2'd1;
    localparam logic [OP_W-1:0] OP_TICK = 2'd2;

    localparam logic [EV_W-1:0] EV_EXPIRY    = 3'd0;
    localparam logic [EV_W-1:0] EV_SET_DONE  = 3'd1;
    localparam logic [EV_W-1:0] EV_FULL      = 3'd2;
    localparam logic [EV_W-1:0] EV_KILLED    = 3'd3;
    localparam logic [EV_W-1:0] EV_NOT_FOUND = 3'd4;
    localparam logic [EV_W-1:0] EV_TICK_NONE = 3'd5;

    typedef struct packed {
        logic [ID_W-1:0]  id;
        logic [PER_W-1:0] period;
        logic [PER_W-1:0] count;
    } slot_entry_t;

endpackage

// ----- src/periodic_timer_table_unit.sv -----
// periodic timer table: slot memory with a one-slot-per-cycle scan that result stalls can hold
// every set, kill or tick scans the slot memory from index 0, one slot per cycle while not stalled (registered read)
// a tick, a set on a full table or a kill that misses scans all NUM_SLOTS slots before its
// final beat; a set or kill that hits slot k stops the scan there with one result beat
// one item in flight: s_tready is high only in ST_IDLE, so the next item is taken once the
// final beat is in the output register; reset (aresetn low, sync) frees all slots, drops beats
module periodic_timer_table_unit
    import ptt_pkg::*;
#(
    parameter int unsigned NUM_SLOTS = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,   // op[1:0], timer_id[17:2], period[49:18]
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,   // event_res[2:0], fired_id[18:3]
    output logic                m_tlast
);

    localparam int unsigned IW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int unsigned CW = $clog2(NUM_SLOTS + 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } state_t;

    state_t state_reg;

    // slot memory
    slot_entry_t slot_mem [NUM_SLOTS];
    slot_entry_t rd_data_reg;
    logic [NUM_SLOTS-1:0] used_reg;

    logic [OP_W-1:0]   op_reg;
    logic [ID_W-1:0]   id_reg;
    logic [PER_W-1:0]  per_reg;
    logic [EV_W-1:0]   code_reg;
    logic [CW-1:0]     iss_reg;
    logic              proc_valid_reg;
    logic [IW-1:0]     proc_idx_reg;
    logic [RCNT_W-1:0] res_cnt_reg;
    logic              pend_valid_reg;
    logic [ID_W-1:0]   pend_id_reg;

    logic              m_valid_reg;
    logic              m_last_reg;
    logic [EV_W-1:0]   m_ev_reg;
    logic [ID_W-1:0]   m_id_reg;

    logic              out_free;
    logic              used_cur;
    logic [PER_W-1:0]  cnt_inc;
    logic              fire;
    logic              report;
    logic              stall;
    logic              proc_go;
    logic              rd_en;
    logic [IW-1:0]     rd_addr;
    logic              wr_en;
    slot_entry_t       wr_data;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tlast  = m_last_reg;
    assign m_tdata  = {{(M_DATA_W - EV_W - ID_W){1'b0}}, m_id_reg, m_ev_reg};

    always_comb begin
        out_free = !m_valid_reg || m_tready;
        used_cur = used_reg[proc_idx_reg];
        cnt_inc  = rd_data_reg.count + 1'b1;
        fire     = (rd_data_reg.period != '0) && (cnt_inc == rd_data_reg.period);
        report   = fire && (res_cnt_reg < RCNT_W'(MAX_OUT));
        // a second expiry needs the pending one pushed into the output register
        stall    = proc_valid_reg && (op_reg == OP_TICK) && used_cur && report
                   && pend_valid_reg && !out_free;
        proc_go  = proc_valid_reg && !stall;
        rd_addr  = iss_reg[IW-1:0];
        rd_en    = (state_reg == ST_SCAN) && (iss_reg != CW'(NUM_SLOTS)) && !stall;

        wr_en   = 1'b0;
        wr_data = rd_data_reg;
        if (proc_go && (op_reg == OP_SET) && !used_cur) begin
            wr_en   = 1'b1;
            wr_data = '{id: id_reg, period: per_reg, count: '0};
        end else if (proc_go && (op_reg == OP_TICK) && used_cur) begin
            wr_en         = 1'b1;
            wr_data.count = fire ? '0 : cnt_inc;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            slot_mem[proc_idx_reg] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= slot_mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            used_reg       <= '0;
            m_valid_reg    <= 1'b0;
            pend_valid_reg <= 1'b0;
            proc_valid_reg <= 1'b0;
            iss_reg        <= '0;
            res_cnt_reg    <= '0;
        end else begin
            if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        op_reg         <= s_tdata[1:0];
                        id_reg         <= s_tdata[17:2];
                        per_reg        <= s_tdata[49:18];
                        iss_reg        <= '0;
                        res_cnt_reg    <= '0;
                        proc_valid_reg <= 1'b0;
                        pend_valid_reg <= 1'b0;
                        unique case (s_tdata[1:0])
                            OP_SET: begin
                                code_reg  <= EV_FULL;
                                state_reg <= ST_SCAN;
                            end
                            OP_KILL: begin
                                code_reg  <= EV_NOT_FOUND;
                                state_reg <= ST_SCAN;
                            end
                            OP_TICK: begin
                                code_reg  <= EV_TICK_NONE;
                                state_reg <= ST_SCAN;
                            end
                            default: ;  // unused opcode: no effect, no result
                        endcase
                    end
                end
                ST_SCAN: begin
                    if (rd_en) begin
                        iss_reg      <= iss_reg + 1'b1;
                        proc_idx_reg <= rd_addr;
                    end
                    proc_valid_reg <= rd_en || stall;
                    if (proc_go) begin
                        unique case (op_reg)
                            OP_SET: begin
                                if (!used_cur) begin
                                    used_reg[proc_idx_reg] <= 1'b1;
                                    code_reg               <= EV_SET_DONE;
                                    state_reg              <= ST_FINISH;
                                    proc_valid_reg         <= 1'b0;
                                end
                            end
                            OP_KILL: begin
                                if (used_cur && (rd_data_reg.id == id_reg)) begin
                                    used_reg[proc_idx_reg] <= 1'b0;
                                    code_reg               <= EV_KILLED;
                                    state_reg              <= ST_FINISH;
                                    proc_valid_reg         <= 1'b0;
                                end
                            end
                            OP_TICK: begin
                                if (used_cur && report) begin
                                    // hold the newest expiry back until its last flag is known
                                    if (pend_valid_reg) begin
                                        m_valid_reg <= 1'b1;
                                        m_last_reg  <= 1'b0;
                                        m_ev_reg    <= EV_EXPIRY;
                                        m_id_reg    <= pend_id_reg;
                                    end
                                    pend_valid_reg <= 1'b1;
                                    pend_id_reg    <= rd_data_reg.id;
                                    res_cnt_reg    <= res_cnt_reg + 1'b1;
                                end
                            end
                            default: ;
                        endcase
                    end
                    if (!proc_valid_reg && (iss_reg == CW'(NUM_SLOTS))) begin
                        state_reg <= ST_FINISH;
                    end
                end
                ST_FINISH: begin
                    if (out_free) begin
                        m_valid_reg <= 1'b1;
                        m_last_reg  <= 1'b1;
                        if (pend_valid_reg) begin
                            m_ev_reg       <= EV_EXPIRY;
                            m_id_reg       <= pend_id_reg;
                            pend_valid_reg <= 1'b0;
                        end else begin
                            m_ev_reg <= code_reg;
                            m_id_reg <= (op_reg == OP_TICK) ? '0 : id_reg;
                        end
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

`ifndef ASSERT_OFF
    a_finish_no_proc: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FINISH) |-> !proc_valid_reg)
        else $error("slot still in flight after scan end");

    a_pend_tick_only: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_valid_reg |-> (op_reg == OP_TICK) && (state_reg != ST_IDLE))
        else $error("pending expiry outside a tick");

    a_res_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        res_cnt_reg <= RCNT_W'(MAX_OUT))
        else $error("expiry count above cap");

    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        stall |-> m_valid_reg && !m_tready && pend_valid_reg)
        else $error("scan stalled without a blocked result");

    a_stall_holds_read: assert property (@(posedge aclk) disable iff (!aresetn)
        stall |=> proc_valid_reg && $stable(proc_idx_reg) && $stable(rd_data_reg))
        else $error("stalled slot data lost");
`endif

endmodule
